[rtl/scrf_pkg.sv]
// Shared types and constants for the sum-checked frame receiver.
// No dependencies; compiled first.
package scrf_pkg;

	// op codes of the command channel
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [7:0] START_BYTE = 8'hFF;

	// classified command as it sits in the queue
	typedef struct packed {
		logic       take;       // received byte
		logic       rd;         // payload read
		logic       rel_frame;  // frame release
		logic [7:0] data;
		logic [7:0] idx;
	} cmd_t;

	// queue head towards the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

[rtl/scrf_if.sv]
// Valid/ready channel interfaces for the frame receiver.
// Depends on nothing; follows scrf_pkg in compile order.
interface scrf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, op, rx_byte, read_index, input ready);
	modport sink   (input valid, op, rx_byte, read_index, output ready);
endinterface

interface scrf_rsp_if;
	logic        valid;
	logic        ready;
	logic        frame_ready;
	logic [7:0]  source_id;
	logic [7:0]  dest_id;
	logic [15:0] frame_type;
	logic [15:0] frame_length;
	logic [7:0]  read_data;
	logic        payload_truncated;

	modport source (output valid, frame_ready, source_id, dest_id, frame_type, frame_length,
		read_data, payload_truncated, input ready);
	modport sink   (input valid, frame_ready, source_id, dest_id, frame_type, frame_length,
		read_data, payload_truncated, output ready);
endinterface

[rtl/sum_checked_frame_receiver_top.sv]
// Sum-checked frame receiver: top level.
// Depends on scrf_pkg, scrf_if, scrf_front and scrf_back.
//
// cmd carries one transaction per received byte (op 0), payload read (op 1)
// or frame release (op 2); op 3 does nothing but still returns a result.
// rsp returns exactly one result transaction per command, in order: the
// held frame's fields (zero while no frame is held), the read byte for a
// read and the truncation flag.
// A taken command is first stored in the queue, then moves into the result
// register when it heads the queue and rsp is free. Throughput: one
// transaction per cycle on both sides while rsp is not stalled, set by the parser
// step and the one write or read port of the payload memory per cycle.
// The front end queues up to four decoded commands; cmd.ready drops only
// when that queue is full, i.e. after rsp has been stalled for a while.
// A stalled result holds its value; parsing pauses with it.
// Reset clears the parser, the held frame and the queue; the payload
// memory is not cleared and needs no clearing pass.
module sum_checked_frame_receiver_top #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	scrf_cmd_if.sink    cmd,
	scrf_rsp_if.source  rsp
);
	import scrf_pkg::*;

	head_t head;
	logic  pop;

	scrf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	scrf_back #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

[rtl/scrf_front.sv]
// Front end: accepts command transactions, decodes op and queues them.
// Depends on scrf_pkg and scrf_cmd_if.
module scrf_front (
	input  logic           clk,
	input  logic           arst_n,
	scrf_cmd_if.sink       cmd,
	output scrf_pkg::head_t head,
	input  logic           pop
);
	import scrf_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;
	cmd_t              decoded;

	assign cmd.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign do_pop    = pop && (count_q != '0);

	always_comb begin
		decoded.take      = (cmd.op == OP_BYTE);
		decoded.rd        = (cmd.op == OP_READ);
		decoded.rel_frame = (cmd.op == OP_RELEASE);
		decoded.data      = cmd.rx_byte;
		decoded.idx       = cmd.read_index;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head = '{valid: (count_q != '0), cmd: entry_q[rd_ptr_q]};

endmodule

[rtl/scrf_back.sv]
// Back end: frame parser, payload store and result register.
// Depends on scrf_pkg and scrf_rsp_if.
module scrf_back #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  scrf_pkg::head_t head,
	output logic            pop,
	scrf_rsp_if.source      rsp
);
	import scrf_pkg::*;

	localparam int          AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [16:0] DEPTH_W = 17'(PAYLOAD_DEPTH);

	localparam logic [3:0] PH_HUNT  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_SRC   = 4'd2;
	localparam logic [3:0] PH_DST   = 4'd3;
	localparam logic [3:0] PH_TYPEL = 4'd4;
	localparam logic [3:0] PH_TYPEH = 4'd5;
	localparam logic [3:0] PH_LENL  = 4'd6;
	localparam logic [3:0] PH_LENH  = 4'd7;
	localparam logic [3:0] PH_HSUM  = 4'd8;
	localparam logic [3:0] PH_DATA  = 4'd9;
	localparam logic [3:0] PH_PSUM  = 4'd10;

	logic [7:0] mem [PAYLOAD_DEPTH];

	logic [3:0]  phase_q, phase_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  src_q, src_n;
	logic [7:0]  dst_q, dst_n;
	logic [15:0] type_q, type_n;
	logic [15:0] len_q, len_n;
	logic [15:0] count_q, count_n;
	logic        ready_q, ready_n;
	logic        ovf_q, ovf_n;
	logic        valid_q;
	logic        rd_hit_q;
	logic [7:0]  rd_data_q;

	logic          fire;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [16:0]   idx_x;
	logic [7:0]    b;

	// state registers always match the result register, so both move together
	assign fire    = head.valid && (!valid_q || rsp.ready);
	assign pop     = fire;
	assign b       = head.cmd.data;
	assign idx_x   = 17'(head.cmd.idx);
	assign rd_addr = idx_x[AW-1:0];
	assign rd_en   = head.cmd.rd && (idx_x < DEPTH_W);
	assign wr_addr = AW'(count_q);

	always_comb begin
		phase_n = phase_q;
		sum_n   = sum_q;
		src_n   = src_q;
		dst_n   = dst_q;
		type_n  = type_q;
		len_n   = len_q;
		count_n = count_q;
		ready_n = ready_q;
		ovf_n   = ovf_q;
		wr_en   = 1'b0;
		if (head.cmd.take && !ready_q) begin
			case (phase_q)
				PH_START: begin
					sum_n   = sum_q + b;
					phase_n = (b == START_BYTE) ? PH_SRC : PH_HUNT;
				end
				PH_SRC: begin
					sum_n   = sum_q + b;
					src_n   = b;
					phase_n = PH_DST;
				end
				PH_DST: begin
					sum_n   = sum_q + b;
					dst_n   = b;
					phase_n = PH_TYPEL;
				end
				PH_TYPEL: begin
					sum_n   = sum_q + b;
					type_n  = {8'd0, b};
					phase_n = PH_TYPEH;
				end
				PH_TYPEH: begin
					sum_n   = sum_q + b;
					type_n  = {b, type_q[7:0]};
					phase_n = PH_LENL;
				end
				PH_LENL: begin
					sum_n   = sum_q + b;
					len_n   = {8'd0, b};
					phase_n = PH_LENH;
				end
				PH_LENH: begin
					sum_n   = sum_q + b;
					len_n   = {b, len_q[7:0]};
					phase_n = PH_HSUM;
				end
				PH_HSUM: begin
					if (sum_q == b) begin
						sum_n   = '0;
						count_n = '0;
						ovf_n   = 1'b0;
						phase_n = (len_q == '0) ? PH_PSUM : PH_DATA;
					end else begin
						phase_n = PH_HUNT;
					end
				end
				PH_DATA: begin
					sum_n = sum_q + b;
					if ({1'b0, count_q} < DEPTH_W) begin
						wr_en = 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
					count_n = count_q + 16'd1;
					if (count_n >= len_q) begin
						phase_n = PH_PSUM;
					end
				end
				PH_PSUM: begin
					if (sum_q == b) begin
						ready_n = 1'b1;
					end
					sum_n   = '0;
					phase_n = PH_HUNT;
				end
				default: begin
					// hunting; unused codes behave the same
					sum_n   = b;
					phase_n = (b == START_BYTE) ? PH_START : PH_HUNT;
				end
			endcase
		end
		if (head.cmd.rel_frame) begin
			ready_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (wr_en) begin
				mem[wr_addr] <= b;
			end
			if (rd_en) begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			sum_q    <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			type_q   <= '0;
			len_q    <= '0;
			count_q  <= '0;
			ready_q  <= 1'b0;
			ovf_q    <= 1'b0;
			valid_q  <= 1'b0;
			rd_hit_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q  <= phase_n;
				sum_q    <= sum_n;
				src_q    <= src_n;
				dst_q    <= dst_n;
				type_q   <= type_n;
				len_q    <= len_n;
				count_q  <= count_n;
				ready_q  <= ready_n;
				ovf_q    <= ovf_n;
				rd_hit_q <= rd_en;
			end
			if (fire) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid             = valid_q;
	assign rsp.frame_ready       = ready_q;
	assign rsp.source_id         = ready_q ? src_q : 8'd0;
	assign rsp.dest_id           = ready_q ? dst_q : 8'd0;
	assign rsp.frame_type        = ready_q ? type_q : 16'd0;
	assign rsp.frame_length      = ready_q ? len_q : 16'd0;
	assign rsp.read_data         = rd_hit_q ? rd_data_q : 8'd0;
	assign rsp.payload_truncated = ready_q && ovf_q;

endmodule

[rtl/scrf_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
// Depends on sum_checked_frame_receiver_top.
module scrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        frame_ready,
	input logic [7:0]  source_id,
	input logic [7:0]  dest_id,
	input logic [15:0] frame_type,
	input logic [15:0] frame_length,
	input logic [7:0]  read_data,
	input logic        payload_truncated
);

	// no frame held: header fields and truncation must read as zero
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !frame_ready) |-> (source_id == 8'd0 && dest_id == 8'd0 &&
		frame_type == 16'd0 && frame_length == 16'd0 && !payload_truncated))
		else $error("fields non-zero without a held frame");

	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(frame_ready) &&
		$stable(read_data) && $stable(frame_length) && $stable(payload_truncated)))
		else $error("stalled result changed");

endmodule

bind sum_checked_frame_receiver_top scrf_checker u_scrf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.frame_ready       (rsp.frame_ready),
	.source_id         (rsp.source_id),
	.dest_id           (rsp.dest_id),
	.frame_type        (rsp.frame_type),
	.frame_length      (rsp.frame_length),
	.read_data         (rsp.read_data),
	.payload_truncated (rsp.payload_truncated)
);

[tb/sv/tb_sum_checked_frame_receiver_top.sv]
// Self-checking testbench for the sum-checked frame receiver: directed frames, then random
// frame streams under varying idle patterns on both channels.
// Depends on scrf_pkg, scrf_if and sum_checked_frame_receiver_top.
module tb_sum_checked_frame_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	import scrf_pkg::*;

	localparam int         STORE_DEPTH = 256;
	localparam logic [1:0] OP_NOP      = 2'd3;
	localparam int         STALL_LIMIT = 2000;
	localparam int         TAIL_CYCLES = 10;

	typedef enum logic [3:0] {
		PH_HUNT, PH_START2, PH_SOURCE, PH_DEST, PH_TYPE_LO, PH_TYPE_HI,
		PH_LEN_LO, PH_LEN_HI, PH_HDR_SUM, PH_PAYLOAD, PH_PAY_SUM
	} parse_phase_e;

	typedef enum int {FAULT_NONE, FAULT_START, FAULT_HDR, FAULT_PAY} frame_fault_e;

	typedef struct packed {
		logic       drain;
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} command_t;

	typedef struct packed {
		logic        frame_ready;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
		logic [15:0] frame_type;
		logic [15:0] frame_length;
		logic [7:0]  read_data;
		logic        payload_truncated;
	} frame_status_t;

	logic clk;
	logic arst_n;

	scrf_cmd_if cmd_ch();
	scrf_rsp_if rsp_ch();

	sum_checked_frame_receiver_top #(
		.PAYLOAD_DEPTH(STORE_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// parser shadow
	parse_phase_e ph;
	logic [7:0]   sum_acc;
	logic [7:0]   src_q;
	logic [7:0]   dst_q;
	logic [15:0]  type_q;
	logic [15:0]  len_q;
	logic [15:0]  pay_cnt;
	logic         held;
	logic         trunc;
	logic [7:0]   payload_mem [STORE_DEPTH];

	command_t      backlog[$];
	frame_status_t awaited[$];

	int  tx_idle_pct;
	int  rx_idle_pct;
	int  queued_total;
	int  accepted_total;
	int  results_total;
	int  frames_held;
	int  frames_truncated;
	int  reads_done;
	int  fails;
	int  idle_run;
	bit  store_filled;
	bit  drain_next;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic frame_status_t parse_step(logic [1:0] op, logic [7:0] b, logic [7:0] idx);
		frame_status_t st;
		st = '0;
		if (op == OP_BYTE && !held) begin
			case (ph)
				PH_START2: begin
					sum_acc += b;
					ph = (b == START_BYTE) ? PH_SOURCE : PH_HUNT;
				end
				PH_SOURCE: begin
					sum_acc += b;
					src_q = b;
					ph = PH_DEST;
				end
				PH_DEST: begin
					sum_acc += b;
					dst_q = b;
					ph = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					sum_acc += b;
					type_q = {8'h00, b};
					ph = PH_TYPE_HI;
				end
				PH_TYPE_HI: begin
					sum_acc += b;
					type_q[15:8] = b;
					ph = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					sum_acc += b;
					len_q = {8'h00, b};
					ph = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					sum_acc += b;
					len_q[15:8] = b;
					ph = PH_HDR_SUM;
				end
				PH_HDR_SUM: begin
					if (sum_acc == b) begin
						sum_acc = '0;
						pay_cnt = '0;
						trunc = 1'b0;
						ph = (len_q == 16'd0) ? PH_PAY_SUM : PH_PAYLOAD;
					end else
						ph = PH_HUNT;
				end
				PH_PAYLOAD: begin
					sum_acc += b;
					if (pay_cnt < STORE_DEPTH)
						payload_mem[pay_cnt[7:0]] = b;
					else
						trunc = 1'b1;
					pay_cnt++;
					if (pay_cnt >= len_q)
						ph = PH_PAY_SUM;
				end
				PH_PAY_SUM: begin
					if (sum_acc == b) begin
						held = 1'b1;
						frames_held++;
						if (trunc)
							frames_truncated++;
					end
					sum_acc = '0;
					ph = PH_HUNT;
				end
				default: begin
					sum_acc = b;
					ph = (b == START_BYTE) ? PH_START2 : PH_HUNT;
				end
			endcase
		end else if (op == OP_READ) begin
			st.read_data = payload_mem[idx];
			reads_done++;
		end else if (op == OP_RELEASE)
			held = 1'b0;

		st.frame_ready = held;
		if (held) begin
			st.source_id         = src_q;
			st.dest_id           = dst_q;
			st.frame_type        = type_q;
			st.frame_length      = len_q;
			st.payload_truncated = trunc;
		end
		return st;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
			fails++;
		end
	endfunction

	// driver: one transaction on the bus at a time, predicted as it is taken
	always @(posedge clk or negedge arst_n) begin : p_driver
		command_t nxt;
		if (!arst_n) begin
			cmd_ch.valid      <= 1'b0;
			cmd_ch.op         <= OP_BYTE;
			cmd_ch.rx_byte    <= '0;
			cmd_ch.read_index <= '0;
			ph      = PH_HUNT;
			sum_acc = '0;
			src_q   = '0;
			dst_q   = '0;
			type_q  = '0;
			len_q   = '0;
			pay_cnt = '0;
			held    = 1'b0;
			trunc   = 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				awaited.push_back(parse_step(cmd_ch.op, cmd_ch.rx_byte, cmd_ch.read_index));
				accepted_total++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct
				    && !(backlog[0].drain && awaited.size() > 0)) begin
					nxt = backlog.pop_front();
					cmd_ch.valid      <= 1'b1;
					cmd_ch.op         <= nxt.op;
					cmd_ch.rx_byte    <= nxt.rx_byte;
					cmd_ch.read_index <= nxt.read_index;
				end else
					cmd_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : p_monitor
		frame_status_t want;
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_total++;
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result, expected none, got ready=%0b read_data='h%0h",
						$time, rsp_ch.frame_ready, rsp_ch.read_data);
					fails++;
				end else begin
					want = awaited.pop_front();
					check_field("frame_ready", 16'(want.frame_ready),
						16'(rsp_ch.frame_ready));
					check_field("source_id", 16'(want.source_id), 16'(rsp_ch.source_id));
					check_field("dest_id", 16'(want.dest_id), 16'(rsp_ch.dest_id));
					check_field("frame_type", want.frame_type, rsp_ch.frame_type);
					check_field("frame_length", want.frame_length, rsp_ch.frame_length);
					check_field("read_data", 16'(want.read_data), 16'(rsp_ch.read_data));
					check_field("payload_truncated", 16'(want.payload_truncated),
						16'(rsp_ch.payload_truncated));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_run);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic push_cmd(logic [1:0] op, logic [7:0] b, logic [7:0] idx);
		command_t c;
		c.drain      = drain_next;
		c.op         = op;
		c.rx_byte    = b;
		c.read_index = idx;
		backlog.push_back(c);
		drain_next = 1'b0;
		queued_total++;
	endtask

	task automatic push_frame(logic [7:0] src, logic [7:0] dst, logic [15:0] typ,
			logic [15:0] len, frame_fault_e fault);
		logic [7:0]  hdr [8];
		logic [7:0]  sum;
		logic [7:0]  b;
		logic [15:0] n;
		n = (fault == FAULT_HDR) ? 16'($urandom) : len;
		hdr = '{START_BYTE, START_BYTE, src, dst, typ[7:0], typ[15:8], n[7:0], n[15:8]};
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			if (fault == FAULT_START && i == 1) begin
				push_cmd(OP_BYTE, 8'($urandom_range(0, 254)), '0);
				return;
			end
			push_cmd(OP_BYTE, hdr[i], '0);
			sum += hdr[i];
		end
		if (fault == FAULT_HDR) begin
			push_cmd(OP_BYTE, sum + 8'($urandom_range(1, 255)), '0);
			return;
		end
		push_cmd(OP_BYTE, sum, '0);
		sum = '0;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			push_cmd(OP_BYTE, b, '0);
			sum += b;
			if (store_filled && $urandom_range(9) == 0)
				push_cmd(OP_READ, 8'($urandom), 8'($urandom));
		end
		if (fault == FAULT_PAY)
			sum += 8'($urandom_range(1, 255));
		push_cmd(OP_BYTE, sum, '0);
		// a header-good frame this long has written every store entry
		if (n >= STORE_DEPTH)
			store_filled = 1'b1;
	endtask

	task automatic run_random(int count);
		int           target;
		int           r;
		logic [15:0]  len;
		logic [1:0]   op;
		frame_fault_e fault;
		target = queued_total + count;
		drain_next = 1'b1;
		while (queued_total < target) begin
			r = $urandom_range(99);
			if (!store_filled)
				push_frame(8'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom_range(257, 262)), FAULT_NONE);
			else if (r < 65) begin
				r = $urandom_range(99);
				fault = (r < 70) ? FAULT_NONE : (r < 80) ? FAULT_START :
					(r < 90) ? FAULT_HDR : FAULT_PAY;
				r = $urandom_range(99);
				if (r < 85)
					len = 16'($urandom_range(0, 12));
				else if (r < 97)
					len = 16'($urandom_range(13, 64));
				else
					len = 16'($urandom_range(250, 270));
				push_frame(8'($urandom), 8'($urandom), 16'($urandom), len, fault);
				repeat ($urandom_range(0, 2))
					push_cmd(OP_READ, 8'($urandom), 8'($urandom));
				if ($urandom_range(9) < 2)
					push_cmd(OP_BYTE, 8'($urandom), 8'($urandom));
				if ($urandom_range(9) != 0)
					push_cmd(OP_RELEASE, 8'($urandom), 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 3)) begin
					op = 2'($urandom_range(0, 3));
					push_cmd(op, 8'($urandom), 8'($urandom));
				end
			end
			if ($urandom_range(49) == 0)
				drain_next = 1'b1;
		end
		while (backlog.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = OP_BYTE;
		cmd_ch.rx_byte    = '0;
		cmd_ch.read_index = '0;
		rsp_ch.ready      = 1'b0;
		idle_run          = 0;
		tx_idle_pct       = 35;
		rx_idle_pct       = 76;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(OP_NOP, 8'hFF, 8'hFF);
		push_cmd(OP_RELEASE, 8'h00, 8'h00);      // nothing held yet
		push_cmd(OP_BYTE, START_BYTE, 8'h00);
		push_cmd(OP_BYTE, 8'h7F, 8'h00);         // broken second start byte
		push_frame(8'hFF, 8'h00, 16'hFFFF, 16'd1, FAULT_NONE);
		push_cmd(OP_BYTE, 8'h00, 8'h00);         // ignored while held
		push_cmd(OP_READ, 8'h00, 8'h00);
		push_cmd(OP_NOP, 8'h00, 8'h00);
		push_cmd(OP_RELEASE, 8'hFF, 8'hFF);
		push_frame(8'h00, 8'hFF, 16'h0000, 16'd0, FAULT_NONE);
		push_cmd(OP_READ, 8'hFF, 8'h00);
		push_cmd(OP_RELEASE, 8'h00, 8'h00);

		run_random(200);
		tx_idle_pct = 76;
		rx_idle_pct = 35;
		run_random(200);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(200);

		while (accepted_total < queued_total || awaited.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d commands driven, %0d results checked, %0d mismatches", accepted_total,
			results_total, fails);
		$display("%0d frames held (%0d truncated), %0d payload reads", frames_held,
			frames_truncated, reads_done);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
